/* hdl/pafm_pkg.sv */
// Package for the period-averaging frequency meter: request types,
// controller command and status structs, register codes and reset values.
// Depends on nothing; used by pafm_datapath, pafm_controller and the top level.
`default_nettype none

package pafm_pkg;

  // Fixed field widths.
  localparam int RATE_W      = 24;
  localparam int THRESH_W    = 10;
  localparam int EDGE_W      = 11;
  localparam int CFG_INDEX_W = 1;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_RATE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_EDGES      = 1'b1;

  // Reset values of the registers.
  localparam logic [RATE_W-1:0]   CLOCK_RATE_RESET = 24'd921600;
  localparam logic [THRESH_W-1:0] EDGES_RESET      = 10'd100;

  // One incoming request: the sampled pin level of one timer tick.
  typedef struct packed {
    logic level;
  } sample_t;

  // One outgoing request: a frequency reading.
  typedef struct packed {
    logic [RATE_W-1:0] frequency;
    logic              zero_period;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic start_avg;
    logic write_avg;
    logic start_freq;
    logic emit;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rising;
    logic div_done;
    logic over_limit;
    logic avg_zero;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

/* hdl/pafm_stream_if.sv */
// Valid/ready channel carrying one request of a chosen payload type.
// Depends on nothing; the payload type is given at instantiation.
`default_nettype none

interface pafm_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/pafm_divider.sv */
// Iterative restoring divider, one quotient bit per cycle.
// Depends on nothing outside this file.
`default_nettype none

module pafm_divider #(
  parameter int DIV_W = 28,
  parameter int DVS_W = 16
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DIV_W-1:0] dividend,
  input  wire logic [DVS_W-1:0] divisor,
  output logic                  done,
  output logic      [DIV_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [DVS_W-1:0] remainder;
  logic [DVS_W-1:0] divisor_q;
  logic [DVS_W:0]   rem_shift;
  logic [DVS_W:0]   difference;

  // Trial subtraction of the divisor from the shifted partial remainder.
  assign rem_shift  = {remainder, quotient[DIV_W-1]};
  assign difference = rem_shift - {1'b0, divisor_q};

  // Control: bit counter, busy flag and a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= busy && (count == CNT_W'(1));
      if (start) begin
        busy  <= 1'b1;
        count <= CNT_W'(DIV_W);
      end else if (busy) begin
        count <= count - CNT_W'(1);
        if (count == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // Datapath: the quotient register shifts the dividend out as quotient bits come in.
  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      divisor_q <= divisor;
    end else if (busy) begin
      if (!difference[DVS_W]) begin
        remainder <= difference[DVS_W-1:0];
        quotient  <= {quotient[DIV_W-2:0], 1'b1};
      end else begin
        remainder <= rem_shift[DVS_W-1:0];
        quotient  <= {quotient[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

`default_nettype wire

/* hdl/pafm_datapath.sv */
// Datapath of the frequency meter: registers, tick counter, running average,
// output register and the shared divider. Depends on pafm_pkg, pafm_divider.
`default_nettype none

module pafm_datapath #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [pafm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pafm_pkg::RATE_W-1:0]   cfg_data,
  input  wire logic                          in_level,
  input  wire pafm_pkg::dp_cmd_t             cmd,
  output pafm_pkg::dp_status_t               status,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output pafm_pkg::result_t                  out_item
);

  localparam int EDGE_W = pafm_pkg::EDGE_W;
  localparam int RATE_W = pafm_pkg::RATE_W;
  localparam int PROD_W = COUNT_WIDTH + EDGE_W;
  localparam int DIV_W  = (COUNT_WIDTH + 12 > RATE_W) ? COUNT_WIDTH + 12 : RATE_W;
  localparam int DVS_W  = (COUNT_WIDTH > 12) ? COUNT_WIDTH : 12;

  logic [RATE_W-1:0]             clock_rate;
  logic [pafm_pkg::THRESH_W-1:0] edges_per_result;
  logic                          prev_level;
  logic [COUNT_WIDTH-1:0]        tick_count;
  logic [COUNT_WIDTH-1:0]        avg_period;
  logic [EDGE_W-1:0]             edge_count;

  logic [PROD_W-1:0] product;
  logic              div_start;
  logic [DIV_W-1:0]  div_dividend;
  logic [DVS_W-1:0]  div_divisor;
  logic              div_done;
  logic [DIV_W-1:0]  div_quotient;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_rate       <= pafm_pkg::CLOCK_RATE_RESET;
      edges_per_result <= pafm_pkg::EDGES_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pafm_pkg::CFG_CLOCK_RATE: clock_rate       <= cfg_data;
        pafm_pkg::CFG_EDGES:      edges_per_result <= cfg_data[pafm_pkg::THRESH_W-1:0];
        default:                  ;
      endcase
    end
  end

  // Measurement state: pin history, tick counter, average and edge count.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_level <= 1'b0;
      tick_count <= '0;
      avg_period <= '0;
      edge_count <= '0;
    end else begin
      if (cmd.accept) begin
        prev_level <= in_level;
        tick_count <= tick_count + COUNT_WIDTH'(1);
      end
      if (cmd.write_avg) begin
        avg_period <= div_quotient[COUNT_WIDTH-1:0];
        tick_count <= '0;
        edge_count <= edge_count + EDGE_W'(1);
      end
      if (cmd.emit) begin
        avg_period <= '0;
        edge_count <= '0;
      end
    end
  end

  // Old average weighted by its edge count; the new period is added at the divider.
  assign product = PROD_W'(avg_period) * PROD_W'(edge_count);

  // Operands for the shared divider.
  assign div_start = cmd.start_avg || cmd.start_freq;
  always_comb begin
    if (cmd.start_freq) begin
      div_dividend = DIV_W'(clock_rate);
      div_divisor  = DVS_W'(avg_period);
    end else begin
      div_dividend = DIV_W'(product) + DIV_W'(tick_count);
      div_divisor  = DVS_W'(edge_count) + DVS_W'(1);
    end
  end

  pafm_divider #(
    .DIV_W (DIV_W),
    .DVS_W (DVS_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Output register: holds a reading until the receiver takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_item.zero_period <= (avg_period == '0);
      out_item.frequency   <= (avg_period == '0) ? '0 : div_quotient[RATE_W-1:0];
    end
  end

  // Status towards the controller.
  assign status.rising     = in_level && !prev_level;
  assign status.div_done   = div_done;
  assign status.over_limit = edge_count > EDGE_W'(edges_per_result);
  assign status.avg_zero   = (avg_period == '0);
  assign status.out_free   = !out_valid || out_ready;

endmodule

`default_nettype wire

/* hdl/pafm_controller.sv */
// Controller of the frequency meter: takes ticks and sequences the averaging
// division, threshold check, final division and output. Depends on pafm_pkg.
`default_nettype none

module pafm_controller (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire pafm_pkg::dp_status_t status,
  output pafm_pkg::dp_cmd_t         cmd
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_MUL      = 6'b000010,
    S_AVG_DIV  = 6'b000100,
    S_CHECK    = 6'b001000,
    S_FREQ_DIV = 6'b010000,
    S_EMIT     = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = status.rising ? S_MUL : S_CHECK;
        end
      end
      S_MUL: begin
        cmd.start_avg = 1'b1;
        state_next    = S_AVG_DIV;
      end
      S_AVG_DIV: begin
        if (status.div_done) begin
          cmd.write_avg = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!status.over_limit) begin
          state_next = S_IDLE;
        end else if (status.avg_zero) begin
          state_next = S_EMIT;
        end else begin
          cmd.start_freq = 1'b1;
          state_next     = S_FREQ_DIV;
        end
      end
      S_FREQ_DIV: begin
        if (status.div_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* hdl/period_average_frequency_meter.sv */
// Period-averaging frequency meter, top level.
// Depends on pafm_pkg, pafm_stream_if, pafm_controller and pafm_datapath.
//
// Each request on the samples channel is one timer tick carrying the sampled
// pin level. Rising edges close a period, which is folded into a truncating
// running average. Once the edge count exceeds edges_per_result, one request
// leaves on the results channel: clock_rate divided by the average period,
// or zero with zero_period set when the average is zero.
// Registers are written through cfg_we, cfg_index and cfg_data; the user must
// do so only while idle, which the block does not enforce. The single
// one-bit-per-cycle divider, DIV_W = max(COUNT_WIDTH + 12, 24) bits (28 by
// default), serves both divisions. Ticks go to the threshold check, rising
// edges first through the averaging division; past the threshold the final
// division follows. One tick is in work at a time. A reading sits in an output
// register; a new tick is taken while it waits, and only a further reading
// stalls until the receiver takes it. Synchronous reset clears the measurement
// and restores clock_rate to 921600 Hz and edges_per_result to 100.
`default_nettype none

module period_average_frequency_meter #(
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_we,
  input  wire logic [pafm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [pafm_pkg::RATE_W-1:0]      cfg_data,
  pafm_stream_if.sink                           samples,
  pafm_stream_if.source                         results
);

  pafm_pkg::dp_cmd_t    cmd;
  pafm_pkg::dp_status_t status;
  pafm_pkg::result_t    out_item;
  logic                 out_valid;

  pafm_controller u_controller (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd)
  );

  pafm_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_level  (samples.data.level),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_ready (results.ready),
    .out_item  (out_item)
  );

  assign results.valid = out_valid;
  assign results.data  = out_item;

  // A zero average always comes out as frequency zero.
  a_zero_period_freq: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.data.zero_period |-> results.data.frequency == '0)
    else $error("zero_period reading with nonzero frequency");

  // After taking a tick the block is busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    samples.valid && samples.ready |=> !samples.ready)
    else $error("tick taken while previous one still in work");

  // A reading is only loaded when the output register is free.
  a_emit_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!results.valid || results.ready))
    else $error("reading overwrote one not yet taken");

endmodule

`default_nettype wire
